### design/bba_pkg.sv
// shared types, constants and helpers of the buddy allocator
package bba_pkg;

  localparam int unsigned SLOT_W  = 15;
  localparam int unsigned WA_W    = 10;
  localparam int unsigned PTR_W   = 11;
  localparam int unsigned HDR_W   = 6;
  localparam int unsigned SLOTS   = 32768;
  localparam int unsigned WORDS   = 1024;
  localparam logic [3:0]  TOP_ORD = 4'd10;
  localparam logic [27:0] TOP_BYTES = 28'd131072;
  localparam logic [22:0] FREE_BYTES_RST = 23'd4193024;
  localparam logic [15:0] BLOCKS_RST = 16'd32;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOBLK = 2'd1;
  localparam logic [1:0] ST_SIZE  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic CFG_HDR = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_CLEAR  = 4'd1;
  localparam logic [3:0] OP_LOAD   = 4'd2;
  localparam logic [3:0] OP_ACHK   = 4'd3;
  localparam logic [3:0] OP_SCAN   = 4'd4;
  localparam logic [3:0] OP_TAKE   = 4'd5;
  localparam logic [3:0] OP_SRD    = 4'd6;
  localparam logic [3:0] OP_SWR    = 4'd7;
  localparam logic [3:0] OP_AFIN   = 4'd8;
  localparam logic [3:0] OP_FCHK   = 4'd9;
  localparam logic [3:0] OP_FHDR   = 4'd10;
  localparam logic [3:0] OP_MRD    = 4'd11;
  localparam logic [3:0] OP_MWR    = 4'd12;
  localparam logic [3:0] OP_RESULT = 4'd13;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] res_code;
  } bba_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic kind;
    logic size_bad;
    logic scan_hit;
    logic scan_none;
    logic split_more;
    logic addr_bad;
    logic hdr_bad;
    logic merge;
    logic out_busy;
  } bba_stat_t;

  // first bitmap word of an order
  function automatic logic [PTR_W-1:0] base_of(input logic [3:0] k);
    base_of = 11'd1024 - (11'd1024 >> k);
  endfunction

  function automatic logic [PTR_W-1:0] end_of(input logic [3:0] k);
    if (k >= TOP_ORD) begin
      end_of = 11'd1024;
    end else begin
      end_of = base_of(k + 4'd1);
    end
  endfunction

  function automatic logic [5:0] lsb64(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) begin
        r = 6'(i);
      end
    end
    lsb64 = r;
  endfunction

endpackage

### design/bba_ctrl.sv
// controller state machine of the buddy allocator
module bba_ctrl import bba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bba_stat_t stat,
  output bba_cmd_t  cmd
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_ACHK = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_TAKE = 4'd5;
  localparam logic [3:0] S_SRD  = 4'd6;
  localparam logic [3:0] S_SWR  = 4'd7;
  localparam logic [3:0] S_AFIN = 4'd8;
  localparam logic [3:0] S_FCHK = 4'd9;
  localparam logic [3:0] S_FHDR = 4'd10;
  localparam logic [3:0] S_MRD  = 4'd11;
  localparam logic [3:0] S_MWR  = 4'd12;
  localparam logic [3:0] S_RES  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [1:0] code_r, code_nxt;

  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    cmd.op       = OP_NONE;
    cmd.res_code = code_r;
    in_ready     = 1'b0;
    case (state_r)
      S_CLR: begin
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_CLEAR;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = stat.kind ? S_FCHK : S_ACHK;
      end
      S_ACHK: begin
        cmd.op = OP_ACHK;
        if (stat.size_bad) begin
          code_nxt  = ST_SIZE;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_hit) begin
          state_nxt = S_TAKE;
        end else if (stat.scan_none) begin
          code_nxt  = ST_NOBLK;
          state_nxt = S_RES;
        end
      end
      S_TAKE: begin
        cmd.op    = OP_TAKE;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        if (stat.split_more) begin
          cmd.op    = OP_SRD;
          state_nxt = S_SWR;
        end else begin
          state_nxt = S_AFIN;
        end
      end
      S_SWR: begin
        cmd.op    = OP_SWR;
        state_nxt = S_SRD;
      end
      S_AFIN: begin
        cmd.op    = OP_AFIN;
        code_nxt  = ST_OK;
        state_nxt = S_RES;
      end
      S_FCHK: begin
        cmd.op = OP_FCHK;
        if (stat.addr_bad) begin
          code_nxt  = ST_BAD;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_FHDR;
        end
      end
      S_FHDR: begin
        cmd.op = OP_FHDR;
        if (stat.hdr_bad) begin
          code_nxt  = ST_BAD;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_MRD;
        end
      end
      S_MRD: begin
        cmd.op    = OP_MRD;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        cmd.op = OP_MWR;
        if (stat.merge) begin
          state_nxt = S_MRD;
        end else begin
          code_nxt  = ST_OK;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

### design/bba_dp.sv
// datapath of the buddy allocator: header and free bitmap memories, counters, result register
module bba_dp import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  bba_cmd_t    cmd,
  output bba_stat_t   stat,
  input  logic        in_kind,
  input  logic [26:0] in_req_bytes,
  input  logic [21:0] in_payload_addr,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [26:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [21:0] out_result_addr,
  output logic [15:0] out_free_block_count,
  output logic [22:0] out_free_byte_count,
  output logic [15:0] out_block_count
);

  logic [HDR_W-1:0] hdr_mem [0:SLOTS-1];
  logic [63:0]      bm_mem  [0:WORDS-1];

  logic             hd_we, hd_re;
  logic [SLOT_W-1:0] hd_wa, hd_ra;
  logic [HDR_W-1:0] hd_wd, hd_rd_r;
  logic             bm_we, bm_re;
  logic [WA_W-1:0]  bm_wa, bm_ra;
  logic [63:0]      bm_wd, bm_rd_r;
  logic [WORDS-1:0] summ_r;

  logic [15:0] clr_r;
  logic [6:0]  hdr_r;
  logic [26:0] max_r;
  logic        kind_r;
  logic [26:0] req_r;
  logic [21:0] paddr_r;
  logic [3:0]  k_r, k_nxt, j_r, o_r;
  logic [PTR_W-1:0] ptr_r;
  logic [WA_W-1:0]  wa_r;
  logic [5:0]  pos_r;
  logic [SLOT_W-1:0] slot_r, bud_r;
  logic [21:0] addr_r;
  logic [15:0] fb_r, tb_r;
  logic [22:0] fy_r;

  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [21:0] raddr_r;
  logic [15:0] ofb_r, otb_r;
  logic [22:0] ofy_r;

  logic [27:0] need;
  logic        size_bad;
  logic [3:0]  chunk;
  logic [63:0] sv, m;
  logic [PTR_W-1:0] endj, nptr, idxc, basej, baseo;
  logic        hit, scan_none;
  logic [WA_W-1:0] hw;
  logic [5:0]  tb_bit;
  logic [WA_W-1:0] rel;
  logic [SLOT_W-1:0] tidx, tslot;
  logic [3:0]  om1;
  logic [SLOT_W-1:0] sbud, sidx, midx, mbud, kbit;
  logic [WA_W-1:0] swa, mwa;
  logic [21:0] off;
  logic        addr_bad, hdr_bad, merge;
  logic [5:0]  bpos;

  // allocate size check and order
  always_comb begin
    need = {1'b0, req_r} + {21'd0, hdr_r};
    size_bad = (req_r == 27'd0) || (req_r > max_r) || (need >= TOP_BYTES);
    k_nxt = TOP_ORD;
    for (int i = 10; i >= 0; i--) begin
      if (need <= (28'd128 << i)) begin
        k_nxt = 4'(i);
      end
    end
  end

  // free-word search over the summary bits
  always_comb begin
    chunk = ptr_r[9:6];
    sv    = summ_r[{chunk, 6'd0} +: 64];
    endj  = end_of(j_r);
    for (int b = 0; b < 64; b++) begin
      idxc = {1'b0, chunk, 6'(b)};
      m[b] = sv[b] && (idxc >= ptr_r) && (idxc < endj);
    end
    hit  = |m;
    hw   = {chunk, lsb64(m)};
    nptr = {({1'b0, chunk} + 5'd1), 6'd0};
    scan_none = !hit && (nptr >= endj) && (j_r == TOP_ORD);
  end

  always_comb begin
    basej  = base_of(j_r);
    tb_bit = lsb64(bm_rd_r);
    rel    = wa_r - basej[WA_W-1:0];
    tidx   = {rel[8:0], tb_bit};
    tslot  = tidx << j_r;
    om1    = o_r - 4'd1;
    sbud   = slot_r + (15'd1 << om1);
    sidx   = sbud >> om1;
    baseo  = base_of(om1);
    swa    = baseo[WA_W-1:0] + {1'b0, sidx[14:6]};
    midx   = slot_r >> k_r;
    baseo  = base_of(k_r);
    mwa    = baseo[WA_W-1:0] + {1'b0, midx[14:6]};
    kbit   = 15'd1 << k_r;
    mbud   = slot_r ^ kbit;
    off    = paddr_r - {15'd0, hdr_r};
    addr_bad = (paddr_r < {15'd0, hdr_r}) || (off[6:0] != 7'd0);
    hdr_bad  = !hd_rd_r[5] || hd_rd_r[4] || (hd_rd_r[3:0] > TOP_ORD);
    bpos     = pos_r ^ 6'd1;
    merge    = (k_r != TOP_ORD) && bm_rd_r[bpos];
  end

  // memory port selection
  always_comb begin
    hd_we = 1'b0; hd_wa = slot_r; hd_wd = '0;
    hd_re = 1'b0; hd_ra = off[21:7];
    bm_we = 1'b0; bm_wa = wa_r; bm_wd = bm_rd_r;
    bm_re = 1'b0; bm_ra = hw;
    case (cmd.op)
      OP_CLEAR: begin
        hd_we = 1'b1;
        hd_wa = clr_r[14:0];
        hd_wd = (clr_r[9:0] == 10'd0) ? {2'b11, TOP_ORD} : 6'd0;
        bm_we = 1'b1;
        bm_wa = clr_r[9:0];
        bm_wd = (clr_r[9:0] == 10'd1023) ? 64'h0000_0000_FFFF_FFFF : 64'd0;
      end
      OP_SCAN: begin
        bm_re = hit;
      end
      OP_TAKE: begin
        bm_we = 1'b1;
        bm_wd = bm_rd_r & ~(64'd1 << tb_bit);
      end
      OP_SRD: begin
        bm_re = 1'b1;
        bm_ra = swa;
      end
      OP_SWR: begin
        bm_we = 1'b1;
        bm_wd = bm_rd_r | (64'd1 << pos_r);
        hd_we = 1'b1;
        hd_wa = bud_r;
        hd_wd = {2'b11, om1};
      end
      OP_AFIN: begin
        hd_we = 1'b1;
        hd_wd = {2'b10, k_r};
      end
      OP_FCHK: begin
        hd_re = 1'b1;
      end
      OP_MRD: begin
        bm_re = 1'b1;
        bm_ra = mwa;
      end
      OP_MWR: begin
        bm_we = 1'b1;
        hd_we = 1'b1;
        if (merge) begin
          bm_wd = bm_rd_r & ~(64'd1 << bpos);
          hd_wa = (mbud > slot_r) ? mbud : slot_r;
          hd_wd = 6'd0;
        end else begin
          bm_wd = bm_rd_r | (64'd1 << pos_r);
          hd_wd = {2'b11, k_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hd_we) begin
      hdr_mem[hd_wa] <= hd_wd;
    end
    if (hd_re) begin
      hd_rd_r <= hdr_mem[hd_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_wa] <= bm_wd;
    end
    if (bm_re) begin
      bm_rd_r <= bm_mem[bm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summ_r <= {1'b1, {(WORDS-1){1'b0}}};
    end else if (bm_we) begin
      summ_r[bm_wa] <= (bm_wd != 64'd0);
    end
  end

  // control and counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      hdr_r       <= 7'd40;
      max_r       <= 27'd100000000;
      fb_r        <= BLOCKS_RST;
      tb_r        <= BLOCKS_RST;
      fy_r        <= FREE_BYTES_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_HDR: hdr_r <= cfg_data[6:0];
          CFG_MAX: max_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.op == OP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: clr_r <= clr_r + 16'd1;
        OP_SWR: begin
          fb_r <= fb_r + 16'd1;
          tb_r <= tb_r + 16'd1;
          fy_r <= fy_r - {16'd0, hdr_r};
        end
        OP_AFIN: begin
          fb_r <= fb_r - 16'd1;
          fy_r <= fy_r - ((23'd128 << k_r) - {16'd0, hdr_r});
        end
        OP_FHDR: begin
          if (!hdr_bad) begin
            fb_r <= fb_r + 16'd1;
            fy_r <= fy_r + (23'd128 << hd_rd_r[3:0]) - {16'd0, hdr_r};
          end
        end
        OP_MWR: begin
          if (merge) begin
            fb_r <= fb_r - 16'd1;
            tb_r <= tb_r - 16'd1;
            fy_r <= fy_r + {16'd0, hdr_r};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r  <= in_kind;
        req_r   <= in_req_bytes;
        paddr_r <= in_payload_addr;
        addr_r  <= '0;
      end
      OP_ACHK: begin
        k_r   <= k_nxt;
        j_r   <= k_nxt;
        ptr_r <= base_of(k_nxt);
      end
      OP_SCAN: begin
        if (hit) begin
          wa_r <= hw;
        end else if (nptr >= endj) begin
          if (j_r != TOP_ORD) begin
            j_r   <= j_r + 4'd1;
            ptr_r <= endj;
          end
        end else begin
          ptr_r <= nptr;
        end
      end
      OP_TAKE: begin
        slot_r <= tslot;
        o_r    <= j_r;
      end
      OP_SRD: begin
        wa_r  <= swa;
        pos_r <= sidx[5:0];
        bud_r <= sbud;
      end
      OP_SWR: begin
        o_r <= om1;
      end
      OP_AFIN: begin
        addr_r <= {slot_r, 7'd0} + {15'd0, hdr_r};
      end
      OP_FCHK: begin
        slot_r <= off[21:7];
      end
      OP_FHDR: begin
        k_r <= hd_rd_r[3:0];
      end
      OP_MRD: begin
        wa_r  <= mwa;
        pos_r <= midx[5:0];
      end
      OP_MWR: begin
        if (merge) begin
          slot_r <= slot_r & ~kbit;
          k_r    <= k_r + 4'd1;
        end
      end
      OP_RESULT: begin
        status_r <= cmd.res_code;
        raddr_r  <= (cmd.res_code == ST_OK) ? addr_r : 22'd0;
        ofb_r    <= fb_r;
        otb_r    <= tb_r;
        ofy_r    <= fy_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.clr_done   = clr_r[15];
    stat.kind       = kind_r;
    stat.size_bad   = size_bad;
    stat.scan_hit   = hit;
    stat.scan_none  = scan_none;
    stat.split_more = (o_r > k_r);
    stat.addr_bad   = addr_bad;
    stat.hdr_bad    = hdr_bad;
    stat.merge      = merge;
    stat.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_result_addr      = raddr_r;
  assign out_free_block_count = ofb_r;
  assign out_free_byte_count  = ofy_r;
  assign out_block_count      = otb_r;

endmodule

### design/buddy_block_allocator_unit.sv
// Binary buddy allocator over 32 top blocks of 128 KiB (orders 0 to 10, 128-byte
// smallest block). After reset a clearing pass initializes the header and bitmap
// memories; no request is taken until it ends, config writes are always taken. Each
// request is handled alone: an allocate checks the size, scans the free summary by
// 64-word chunks per order searched (up to 22 chunks), takes a block and splits it
// with a bitmap read and write per split; a free checks the address and header and
// merges with a bitmap read and write per merge. One result follows every request.
module buddy_block_allocator_unit import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [26:0] in_req_bytes,
  input  logic [21:0] in_payload_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [21:0] out_result_addr,
  output logic [15:0] out_free_block_count,
  output logic [22:0] out_free_byte_count,
  output logic [15:0] out_block_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [26:0] cfg_data
);

  bba_cmd_t  cmd;
  bba_stat_t stat;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_kind              (in_kind),
    .in_req_bytes         (in_req_bytes),
    .in_payload_addr      (in_payload_addr),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_result_addr      (out_result_addr),
    .out_free_block_count (out_free_block_count),
    .out_free_byte_count  (out_free_byte_count),
    .out_block_count      (out_block_count)
  );

endmodule

### design/bba_chk.sv
// port-level assertions of the buddy allocator and their bind
module bba_chk import bba_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [21:0] out_result_addr,
  input logic [15:0] out_free_block_count,
  input logic [15:0] out_block_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_addr) && $stable(out_status))
    else $error("stalled result changed");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_result_addr == 22'd0)
    else $error("address set on failed request");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_block_count <= out_block_count)
    else $error("more free blocks than blocks");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind buddy_block_allocator_unit bba_chk u_chk (.*);
